>>> rtl/core/sgdm_pkg.sv
package sgdm_pkg;

    localparam int WEIGHT_DEPTH = 4096;
    localparam int IDX_W        = 12;
    localparam int ADDR_W       = $clog2(WEIGHT_DEPTH);
    localparam int DATA_W       = 32;
    localparam int QDEPTH       = 2;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_ACCUM = 2'd1,
        FN_APPLY = 2'd2,
        FN_READ  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_LEARN_RATE = 2'd0,
        CFG_MOMENTUM   = 2'd1,
        CFG_DECAY_STR  = 2'd2,
        CFG_DECAY_MODE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DM_NONE = 2'd0,
        DM_L1   = 2'd1,
        DM_L2   = 2'd2,
        DM_RSVD = 2'd3
    } t_decay_mode;

    typedef struct packed {
        t_func             func;
        logic [IDX_W-1:0]  index;
        logic              in_range;
        logic [DATA_W-1:0] operand;
    } t_cmd;

    typedef struct packed {
        logic [19:0] learn_rate;
        logic [16:0] momentum_gain;
        logic [16:0] decay_strength;
        t_decay_mode decay_mode;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_REG,
        ST_GRAD,
        ST_PROD,
        ST_SUM,
        ST_WRITE,
        ST_OUT
    } t_state;

    // Saturate a 34-bit signed value to 32 bits.
    function automatic logic [DATA_W:0] sat34(input logic signed [33:0] v);
        logic [DATA_W:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < -34'sh0_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    // Round-half-up to Q16.16 and saturate a 53-bit signed product.
    function automatic logic [DATA_W:0] rnd_sat(input logic signed [52:0] p);
        logic signed [52:0] y;
        logic signed [36:0] s;
        logic [DATA_W:0]    r;
        y = p + 53'sd32768;
        s = y[52:16];
        if (s > 37'sh0_7FFF_FFFF) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (s < -37'sh0_8000_0000) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, s[31:0]};
        end
        return r;
    endfunction

endpackage

>>> rtl/core/sgdm_front.sv
module sgdm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_func,
    input  logic [11:0]    i_weight_index,
    input  logic [31:0]    i_operand_value,
    output sgdm_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_take
);
    import sgdm_pkg::*;

    t_cmd                r_q [QDEPTH];
    logic                r_wp, n_wp;
    logic                r_rp, n_rp;
    logic [1:0]          r_cnt, n_cnt;
    logic                push;
    t_cmd                w_cmd;

    assign o_ready     = (r_cnt != 2'(QDEPTH));
    assign push        = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Classify: tag items whose index lies beyond the store.
    always_comb begin
        w_cmd.func     = t_func'(i_func);
        w_cmd.index    = i_weight_index;
        w_cmd.in_range = (32'(i_weight_index) < 32'(WEIGHT_DEPTH));
        w_cmd.operand  = i_operand_value;
    end

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = i_cmd_take ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(i_cmd_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

>>> rtl/core/sgdm_back.sv
module sgdm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sgdm_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_take,
    input  sgdm_pkg::t_cfg i_cfg,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [11:0]    o_echo_index,
    output logic [31:0]    o_weight_value,
    output logic [31:0]    o_gradient_sum,
    output logic           o_saturated
);
    import sgdm_pkg::*;

    logic [DATA_W-1:0] r_wmem [WEIGHT_DEPTH];
    logic [DATA_W-1:0] r_dmem [WEIGHT_DEPTH];
    logic [DATA_W-1:0] r_gmem [WEIGHT_DEPTH];

    t_state            r_state, n_state;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_w, r_d, r_g;
    logic [DATA_W-1:0] r_reg, r_grad, r_p1, r_p2, r_delta;
    logic              r_flag;
    logic              r_ov;
    logic [DATA_W-1:0] r_ow, r_og;
    logic              r_clr;
    logic [ADDR_W-1:0] r_clr_addr;

    logic [ADDR_W-1:0] addr;
    logic [DATA_W:0]   s_acc, s_reg, s_grad, s_p1, s_p2, s_sum, s_w;
    logic              we;

    assign addr = r_cmd.index[ADDR_W-1:0];

    assign s_acc  = sat34(34'(signed'(r_g)) + 34'(signed'(r_cmd.operand)));
    assign s_reg  = rnd_sat(53'(signed'(r_w)) * 53'(signed'({1'b0, i_cfg.decay_strength})));
    assign s_grad = sat34(34'(signed'(r_g)) + 34'(signed'(r_reg)));
    assign s_p1   = rnd_sat(53'(signed'(r_grad)) * 53'(signed'({1'b0, i_cfg.learn_rate})));
    assign s_p2   = rnd_sat(53'(signed'(r_d)) * 53'(signed'({1'b0, i_cfg.momentum_gain})));
    assign s_sum  = sat34(34'(signed'(r_p1)) + 34'(signed'(r_p2)));
    assign s_w    = sat34(34'(signed'(r_w)) - 34'(signed'(r_delta)));

    assign o_valid        = r_ov;
    assign o_echo_index   = r_cmd.index;
    assign o_weight_value = r_ow;
    assign o_gradient_sum = r_og;
    assign o_saturated    = r_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd_take = 1'b0;
        we         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !r_ov && !r_clr) begin
                    o_cmd_take = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ:  n_state = (r_cmd.func == FN_APPLY && r_cmd.in_range) ? ST_REG : ST_WRITE;
            ST_REG:   n_state = ST_GRAD;
            ST_GRAD:  n_state = ST_PROD;
            ST_PROD:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_WRITE;
            ST_WRITE: begin
                we      = r_cmd.in_range;
                n_state = ST_OUT;
            end
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_ov       <= 1'b0;
        end else begin
            // Sweep delta and accumulator stores to zero once after reset.
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(WEIGHT_DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == ST_OUT) begin
                r_ov <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd  <= i_cmd;
            r_flag <= 1'b0;
        end
        case (r_state)
            ST_READ: begin
                r_w <= r_wmem[addr];
                r_d <= r_dmem[addr];
                r_g <= r_gmem[addr];
            end
            ST_REG: begin
                case (i_cfg.decay_mode)
                    DM_L1: begin
                        if (r_w == '0) begin
                            r_reg <= '0;
                        end else if (r_w[DATA_W-1]) begin
                            r_reg <= -DATA_W'(i_cfg.decay_strength);
                        end else begin
                            r_reg <= DATA_W'(i_cfg.decay_strength);
                        end
                    end
                    DM_L2: begin
                        r_reg  <= s_reg[DATA_W-1:0];
                        r_flag <= r_flag | s_reg[DATA_W];
                    end
                    default: r_reg <= '0;
                endcase
            end
            ST_GRAD: begin
                r_grad <= s_grad[DATA_W-1:0];
                r_flag <= r_flag | s_grad[DATA_W];
            end
            ST_PROD: begin
                r_p1   <= s_p1[DATA_W-1:0];
                r_p2   <= s_p2[DATA_W-1:0];
                r_flag <= r_flag | s_p1[DATA_W] | s_p2[DATA_W];
            end
            ST_SUM: begin
                r_delta <= s_sum[DATA_W-1:0];
                r_flag  <= r_flag | s_sum[DATA_W];
            end
            ST_WRITE: begin
                if (!r_cmd.in_range) begin
                    r_ow <= '0;
                    r_og <= '0;
                end else begin
                    case (r_cmd.func)
                        FN_LOAD: begin
                            r_ow <= r_cmd.operand;
                            r_og <= '0;
                        end
                        FN_ACCUM: begin
                            r_ow   <= r_w;
                            r_og   <= s_acc[DATA_W-1:0];
                            r_flag <= s_acc[DATA_W];
                        end
                        FN_APPLY: begin
                            r_ow   <= s_w[DATA_W-1:0];
                            r_og   <= '0;
                            r_flag <= r_flag | s_w[DATA_W];
                        end
                        default: begin
                            r_ow <= r_w;
                            r_og <= r_g;
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Memory writes for the addressed entry, and the clearing sweep after reset.
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_dmem[r_clr_addr] <= '0;
            r_gmem[r_clr_addr] <= '0;
        end else if (we) begin
            case (r_cmd.func)
                FN_LOAD: begin
                    r_wmem[addr] <= r_cmd.operand;
                    r_dmem[addr] <= '0;
                    r_gmem[addr] <= '0;
                end
                FN_ACCUM: begin
                    r_dmem[addr] <= r_d;
                    r_gmem[addr] <= s_acc[DATA_W-1:0];
                end
                FN_APPLY: begin
                    r_wmem[addr] <= s_w[DATA_W-1:0];
                    r_dmem[addr] <= r_delta;
                    r_gmem[addr] <= '0;
                end
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/sgd_momentum_weight_update.sv
// Each item is taken from the queue, read from the stores, written back and presented;
// apply adds decay, gradient, product and sum steps between read and write-back. The
// single execute sequencer handles one item at a time: read, arithmetic steps and
// write-back of the three stores. A two-entry queue lets the input accept while the
// back end is busy. Reset (synchronous, active low) restores the registers, then a pass
// clears the delta and accumulator stores; no item is executed until that pass ends.
module sgd_momentum_weight_update (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [11:0] i_weight_index,
    input  logic [31:0] i_operand_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_echo_index,
    output logic [31:0] o_weight_value,
    output logic [31:0] o_gradient_sum,
    output logic        o_saturated
);
    import sgdm_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid, cmd_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_rate     <= 20'd655;
            r_cfg.momentum_gain  <= 17'd58982;
            r_cfg.decay_strength <= 17'd0;
            r_cfg.decay_mode     <= DM_NONE;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LEARN_RATE: r_cfg.learn_rate     <= i_cfg_data;
                CFG_MOMENTUM:   r_cfg.momentum_gain  <= i_cfg_data[16:0];
                CFG_DECAY_STR:  r_cfg.decay_strength <= i_cfg_data[16:0];
                CFG_DECAY_MODE: r_cfg.decay_mode     <= t_decay_mode'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    sgdm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_weight_index  (i_weight_index),
        .i_operand_value (i_operand_value),
        .o_cmd           (cmd),
        .o_cmd_valid     (cmd_valid),
        .i_cmd_take      (cmd_take)
    );

    sgdm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_take     (cmd_take),
        .i_cfg          (r_cfg),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_echo_index   (o_echo_index),
        .o_weight_value (o_weight_value),
        .o_gradient_sum (o_gradient_sum),
        .o_saturated    (o_saturated)
    );

endmodule
